// ===== hw/rtl/gcd_lcm_unit_defines.svh =====
// Assertion macros shared by the gcd/lcm unit RTL.
`ifndef GCD_LCM_UNIT_DEFINES_SVH
`define GCD_LCM_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GLU_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gcd_lcm_unit: check failed");

// Next-cycle implication, checked outside reset.
`define GLU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gcd_lcm_unit: check failed");

`endif

// ===== hw/rtl/glu_pkg.sv =====
// Shared constants and types of the gcd/lcm unit.
package glu_pkg;

    localparam int OPERAND_WIDTH_DEF = 32;
    localparam int GCD_VALUE_W       = 32;
    localparam int LCM_VALUE_W       = 63;

    typedef struct packed {
        logic busy;
        logic done;
    } t_lcm_stat;

endpackage

// ===== hw/rtl/gcd_lcm_unit.sv =====
// Top level of the gcd/lcm unit: operand magnitudes, binary gcd, lcm sequencing.
// Sequence: binary-gcd steps, then renormalizing shifts, then a bit-serial divide and
//   multiply in the lcm unit.
// Throughput: one item at a time; busy stays high from the start transfer to the result.
// Results appear for one cycle on o_valid and cannot be stalled.
// Reset (i_rst_n low, synchronous) drops any item in flight and returns to idle.
`include "gcd_lcm_unit_defines.svh"

module gcd_lcm_unit #(
    parameter int OPERAND_WIDTH = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [31:0]                      i_operand_a,
    input  logic [31:0]                      i_operand_b,
    output logic                             o_valid,
    output logic [glu_pkg::GCD_VALUE_W-1:0]  o_gcd_value,
    output logic [glu_pkg::LCM_VALUE_W-1:0]  o_lcm_value
);

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_GCD   = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_LCM   = 2'd3;

    logic [1:0]     r_state, n_state;
    logic [W-1:0]   r_x, n_x;
    logic [W-1:0]   r_y, n_y;
    logic [KW-1:0]  r_k, n_k;
    logic [W-1:0]   r_mag_a, n_mag_a;
    logic [W-1:0]   r_mag_b, n_mag_b;
    logic [W-1:0]   r_gcd, n_gcd;
    logic [2*W-1:0] r_lcm, n_lcm;
    logic           r_valid, n_valid;
    logic           lcm_go;

    logic [W-1:0]   field_a, field_b;
    logic [W-1:0]   mag_a, mag_b;
    logic [W:0]     x_minus_y;
    logic [W:0]     y_minus_x;

    glu_pkg::t_lcm_stat lcm_stat;
    logic [2*W-1:0]     lcm_product;

    // Magnitude of a W-bit two's-complement operand; the most negative value maps to 2^(W-1).
    assign field_a = i_operand_a[W-1:0];
    assign field_b = i_operand_b[W-1:0];
    assign mag_a   = field_a[W-1] ? (~field_a + 1'b1) : field_a;
    assign mag_b   = field_b[W-1] ? (~field_b + 1'b1) : field_b;

    assign x_minus_y = {1'b0, r_x} - {1'b0, r_y};
    assign y_minus_x = {1'b0, r_y} - {1'b0, r_x};

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_mag_a = r_mag_a;
        n_mag_b = r_mag_b;
        n_gcd   = r_gcd;
        n_lcm   = r_lcm;
        n_valid = 1'b0;
        lcm_go  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_GCD;
                    n_x     = mag_a;
                    n_y     = mag_b;
                    n_k     = '0;
                    n_mag_a = mag_a;
                    n_mag_b = mag_b;
                end
            end
            S_GCD: begin
                // One binary-gcd step per cycle; the answer ends up in r_x, scaled by 2^r_k.
                priority if (r_x == '0) begin
                    n_x     = r_y;
                    n_state = S_SHIFT;
                end else if (r_y == '0) begin
                    n_state = S_SHIFT;
                end else if (!r_x[0] && !r_y[0]) begin
                    // common factor of two: pull it out and count it
                    n_x = {1'b0, r_x[W-1:1]};
                    n_y = {1'b0, r_y[W-1:1]};
                    n_k = r_k + 1'b1;
                end else if (!r_x[0]) begin
                    n_x = {1'b0, r_x[W-1:1]};
                end else if (!r_y[0]) begin
                    n_y = {1'b0, r_y[W-1:1]};
                end else if (r_x == r_y) begin
                    n_state = S_SHIFT;
                end else if (!x_minus_y[W]) begin
                    // both odd: the difference is even, halve it right away
                    n_x = x_minus_y[W:1];
                end else begin
                    n_y = y_minus_x[W:1];
                end
            end
            S_SHIFT: begin
                // Restore the common power of two one bit a cycle.
                if (r_k == '0) begin
                    n_gcd = r_x;
                    if ((r_mag_a == '0) || (r_mag_b == '0)) begin
                        // lcm with a zero operand is zero: skip the divide/multiply
                        n_lcm   = '0;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        lcm_go  = 1'b1;
                        n_state = S_LCM;
                    end
                end else begin
                    n_x = {r_x[W-2:0], 1'b0};
                    n_k = r_k - 1'b1;
                end
            end
            S_LCM: begin
                // Hold until the serial divide and multiply are through.
                if (lcm_stat.done) begin
                    n_lcm   = lcm_product;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_k     <= n_k;
        r_mag_a <= n_mag_a;
        r_mag_b <= n_mag_b;
        r_gcd   <= n_gcd;
        r_lcm   <= n_lcm;
    end

    // lcm = (|a| / gcd) * |b|, exact in 2*W bits
    glu_lcm_serial #(
        .W(W)
    ) u_lcm (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (lcm_go),
        .i_dividend (r_mag_a),
        .i_divisor  (r_x),
        .i_mult     (r_mag_b),
        .o_stat     (lcm_stat),
        .o_product  (lcm_product)
    );

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_valid;
    assign o_gcd_value = glu_pkg::GCD_VALUE_W'(r_gcd);
    assign o_lcm_value = glu_pkg::LCM_VALUE_W'(r_lcm);

    // A result only ever appears once the sequencer is back in idle.
    `GLU_ASSERT_SAME(a_valid_idle, i_clk, i_rst_n, r_valid, r_state == S_IDLE)
    // A start transfer always launches the gcd pass.
    `GLU_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, r_state == S_GCD)
    // The lcm unit reports completion only while the sequencer waits for it.
    `GLU_ASSERT_SAME(a_lcm_done_wait, i_clk, i_rst_n, lcm_stat.done, r_state == S_LCM)
    // The lcm unit only works while the sequencer waits for it.
    `GLU_ASSERT_SAME(a_lcm_busy_wait, i_clk, i_rst_n, lcm_stat.busy, r_state == S_LCM)
    // A zero gcd means both operands were zero, so the lcm must be zero too.
    `GLU_ASSERT_SAME(a_zero_gcd_lcm, i_clk, i_rst_n, r_valid && (r_gcd == '0), r_lcm == '0)

endmodule

// ===== hw/rtl/glu_lcm_serial.sv =====
// Bit-serial lcm datapath: restoring divide of |a| by gcd, then shift-add multiply by |b|.
module glu_lcm_serial #(
    parameter int W = glu_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  logic [W-1:0]        i_dividend,
    input  logic [W-1:0]        i_divisor,
    input  logic [W-1:0]        i_mult,
    output glu_pkg::t_lcm_stat  o_stat,
    output logic [2*W-1:0]      o_product
);

    localparam int CW = $clog2(W + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_DIV  = 2'd1;
    localparam logic [1:0] P_MUL  = 2'd2;

    logic [1:0]    r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    // r_hi holds the remainder while dividing and the upper product half while multiplying;
    // r_lo holds dividend/quotient, then multiplier/lower product half.
    logic [W-1:0]  r_hi, n_hi;
    logic [W-1:0]  r_lo, n_lo;
    logic [W-1:0]  r_div, n_div;
    logic [W-1:0]  r_mc, n_mc;

    logic [W:0]    shifted;
    logic [W:0]    trial;
    logic [W:0]    sum;

    assign shifted = {r_hi, r_lo[W-1]};
    assign trial   = shifted - {1'b0, r_div};
    assign sum     = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : '0);

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_div   = r_div;
        n_mc    = r_mc;
        unique case (r_phase)
            P_IDLE: begin
                if (i_go) begin
                    n_phase = P_DIV;
                    n_cnt   = CW'(W);
                    n_hi    = '0;
                    n_lo    = i_dividend;
                    n_div   = i_divisor;
                    n_mc    = i_mult;
                end
            end
            P_DIV: begin
                // one quotient bit per cycle
                if (trial[W]) begin
                    n_hi = shifted[W-1:0];
                    n_lo = {r_lo[W-2:0], 1'b0};
                end else begin
                    n_hi = trial[W-1:0];
                    n_lo = {r_lo[W-2:0], 1'b1};
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_phase = P_MUL;
                    n_cnt   = CW'(W);
                    n_hi    = '0;
                end
            end
            P_MUL: begin
                // one multiplier bit per cycle, product shifts right
                n_hi  = sum[W:1];
                n_lo  = {sum[0], r_lo[W-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_phase = P_IDLE;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_phase = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_div <= n_div;
        r_mc  <= n_mc;
    end

    assign o_stat.busy = (r_phase != P_IDLE);
    assign o_stat.done = r_done;
    assign o_product   = {r_hi, r_lo};

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for gcd_lcm_unit: directed and random operands, result check.
`timescale 1ns / 100ps

module testbench;

    localparam int  CLK_PERIOD   = 12;
    localparam int  RESET_CYCLES = 5;
    localparam int  RANDOM_ITEMS = 800;
    localparam int  MAX_GAP      = 220;
    // Allow a margin at the end of the run for stray results.
    localparam int  DRAIN_CYCLES = 400;
    localparam int  CYCLE_LIMIT  = 1_500_000;

    // Hold the expected gcd/lcm pairs in transfer order and compare results against them.
    class gcd_lcm_scoreboard;

        typedef struct {
            logic [31:0]                     operand_a;
            logic [31:0]                     operand_b;
            logic [glu_pkg::GCD_VALUE_W-1:0] gcd_value;
            logic [glu_pkg::LCM_VALUE_W-1:0] lcm_value;
        } t_gcd_lcm_pair;

        t_gcd_lcm_pair pending_results[$];
        int unsigned   mismatches;
        int unsigned   transfers;
        int unsigned   results_checked;
        int unsigned   zero_operand_items;
        int unsigned   most_negative_items;

        function new();
            mismatches          = 0;
            transfers           = 0;
            results_checked     = 0;
            zero_operand_items  = 0;
            most_negative_items = 0;
        endfunction

        // Magnitudes in 64 bits, Euclid's remainder loop, then lcm as (|a| / gcd) * |b|.
        function t_gcd_lcm_pair predict_gcd_lcm(logic [31:0] a, logic [31:0] b);
            t_gcd_lcm_pair pair;
            logic [63:0]   mag_a;
            logic [63:0]   mag_b;
            logic [63:0]   x;
            logic [63:0]   y;
            logic [63:0]   rem;
            logic [63:0]   product;
            mag_a = a[31] ? (64'h1_0000_0000 - {32'd0, a}) : {32'd0, a};
            mag_b = b[31] ? (64'h1_0000_0000 - {32'd0, b}) : {32'd0, b};
            x = mag_a;
            y = mag_b;
            while (y != 0) begin
                rem = x % y;
                x   = y;
                y   = rem;
            end
            product = 64'd0;
            if (mag_a != 0 && mag_b != 0 && x != 0) begin
                product = (mag_a / x) * mag_b;
            end
            pair.operand_a = a;
            pair.operand_b = b;
            pair.gcd_value = x[glu_pkg::GCD_VALUE_W-1:0];
            pair.lcm_value = product[glu_pkg::LCM_VALUE_W-1:0];
            return pair;
        endfunction

        function void note_operands(logic [31:0] a, logic [31:0] b);
            transfers++;
            if (a == 0 || b == 0) zero_operand_items++;
            if (a == 32'h8000_0000 || b == 32'h8000_0000) most_negative_items++;
            pending_results.insert(pending_results.size(), predict_gcd_lcm(a, b));
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] MISMATCH %s", $realtime, what);
        endtask

        task check_result(logic [glu_pkg::GCD_VALUE_W-1:0] gcd_value,
                          logic [glu_pkg::LCM_VALUE_W-1:0] lcm_value);
            t_gcd_lcm_pair want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result gcd=%0d lcm=%0d",
                                          gcd_value, lcm_value));
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (gcd_value !== want.gcd_value) begin
                    report_mismatch($sformatf("gcd a=%h b=%h got %0d want %0d",
                                              want.operand_a, want.operand_b,
                                              gcd_value, want.gcd_value));
                end
                if (lcm_value !== want.lcm_value) begin
                    report_mismatch($sformatf("lcm a=%h b=%h got %0d want %0d",
                                              want.operand_a, want.operand_b,
                                              lcm_value, want.lcm_value));
                end
            end
        endtask

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    logic [31:0]                     i_operand_a;
    logic [31:0]                     i_operand_b;
    logic                            o_valid;
    logic [glu_pkg::GCD_VALUE_W-1:0] o_gcd_value;
    logic [glu_pkg::LCM_VALUE_W-1:0] o_lcm_value;

    int unsigned        cycle_count;
    gcd_lcm_scoreboard  gcd_lcm_sb = new();

    gcd_lcm_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (o_valid),
        .o_gcd_value (o_gcd_value),
        .o_lcm_value (o_lcm_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: end the run if the unit hangs or a result never shows up.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, gcd_lcm_sb.outstanding());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Sample at the rising edge: a transfer happens when start is high and busy low;
    // a result is taken on any edge where o_valid is high, since it cannot be stalled.
    // Note the transfer first so that a result in the same cycle still pops the older entry.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                gcd_lcm_sb.note_operands(i_operand_a, i_operand_b);
            end
            if (o_valid) begin
                gcd_lcm_sb.check_result(o_gcd_value, o_lcm_value);
            end
        end
    end

    // Offer one operand pair and hold it until the unit takes it.
    // With probability idle_pct, first drop start for a random gap and drive junk operands,
    // so the gap lands on some random point of the unit's work (or past its result).
    task automatic transfer_operands(input logic [31:0] a, input logic [31:0] b,
                                     input int unsigned idle_pct);
        int unsigned gap;
        gap = 0;
        if ($urandom_range(1, 100) <= idle_pct) gap = $urandom_range(1, MAX_GAP);
        if (gap != 0) begin
            start       <= 1'b0;
            i_operand_a <= $urandom();
            i_operand_b <= $urandom();
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operand_a <= a;
        i_operand_b <= b;
        // busy read right after the edge is its value at that edge.
        do @(posedge i_clk); while (busy);
    endtask

    // Draw one random operand pair; the mix favors shared factors and structured values
    // so the lcm path sees large gcds, not only the coprime pairs that plain random gives.
    task automatic draw_operands(output logic [31:0] a, output logic [31:0] b);
        logic [31:0] factor;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                a = $urandom();
                b = $urandom();
            end
            4, 5, 6: begin
                factor = $urandom() >> $urandom_range(0, 31);
                a = factor * $urandom_range(1, 300);
                b = factor * $urandom_range(1, 300);
            end
            7: begin
                case ($urandom_range(0, 5))
                    0: a = 32'd0;
                    1: a = 32'd1;
                    2: a = 32'hFFFF_FFFF;
                    3: a = 32'h8000_0000;
                    4: a = 32'h7FFF_FFFF;
                    default: a = 32'h8000_0001;
                endcase
                b = $urandom();
                if ($urandom_range(0, 1)) begin
                    factor = a;
                    a      = b;
                    b      = factor;
                end
            end
            8: begin
                a = $urandom_range(1, 1023) << $urandom_range(0, 22);
                b = $urandom_range(1, 1023) << $urandom_range(0, 22);
            end
            default: begin
                a = $urandom_range(0, 128) - 64;
                b = $urandom_range(0, 128) - 64;
            end
        endcase
        if ($urandom_range(0, 3) == 0) a = -a;
        if ($urandom_range(0, 3) == 0) b = -b;
    endtask

    initial begin
        logic [31:0] dir_a[$];
        logic [31:0] dir_b[$];
        logic [31:0] a;
        logic [31:0] b;
        int unsigned idle_pct[3];
        int unsigned phase_items;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operand_a <= 32'd0;
        i_operand_b <= 32'd0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pairs: zeros, extremes, most negative, worst-case Euclid, big shared gcd.
        dir_a = '{32'd0,          32'd0,          32'd7,          32'd0,
                  32'h8000_0000,  32'h8000_0000,  32'h7FFF_FFFF,  32'h7FFF_FFFF,
                  32'hFFFF_FFFF,  32'd1,          32'h8000_0000,  32'd12,
                  -32'sd12,       32'h4000_0000,  32'h8000_0000,  32'd2147483647,
                  32'd1836311903, -32'sd1836311903, 32'h7FFF_0000, -32'sd6,
                  32'h8000_0001,  32'hFFFF_FFFF};
        dir_b = '{32'd0,          32'd5,          32'd0,          32'h8000_0000,
                  32'h8000_0000,  32'h7FFF_FFFF,  32'h7FFF_FFFF,  32'h7FFF_FFFE,
                  32'hFFFF_FFFF,  32'hFFFF_FFFF,  32'd0,          32'd18,
                  32'd18,         32'h0010_0000,  32'd6,          32'd2147483629,
                  32'd1134903170, 32'd1134903170, 32'h3FFF_8000,  -32'sd4,
                  32'h8000_0001,  32'h8000_0000};
        foreach (dir_a[i]) transfer_operands(dir_a[i], dir_b[i], 0);

        // Random part in three idling phases: none, sender idle often, sender idle sometimes.
        idle_pct    = '{0, 81, 35};
        phase_items = RANDOM_ITEMS / 3;
        foreach (idle_pct[p]) begin
            repeat (phase_items) begin
                draw_operands(a, b);
                transfer_operands(a, b, idle_pct[p]);
            end
        end
        start <= 1'b0;

        // Drain: wait for every result, then give stray results time to show up.
        while (gcd_lcm_sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d operand transfers (%0d with a zero operand, %0d with the most negative),",
                 gcd_lcm_sb.transfers, gcd_lcm_sb.zero_operand_items,
                 gcd_lcm_sb.most_negative_items);
        $display("checked %0d results over three idling phases, %0d mismatches.",
                 gcd_lcm_sb.results_checked, gcd_lcm_sb.mismatches);
        if (gcd_lcm_sb.mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ===== gcd_lcm_unit.f =====
+incdir+hw/rtl
hw/rtl/glu_pkg.sv
hw/rtl/glu_lcm_serial.sv
hw/rtl/gcd_lcm_unit.sv
tb/testbench.sv
